### rtl/rpnsc_pkg.sv
// Shared types and constants for the RPN stack calculator.
`default_nettype none
package rpnsc_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned VAL_W  = 31;
  localparam int unsigned ACT_W  = 3;
  localparam int unsigned CNT_OUT_W = 5;

  localparam logic [ACT_W-1:0] ACT_PUSH  = 3'd0;
  localparam logic [ACT_W-1:0] ACT_ADD   = 3'd1;
  localparam logic [ACT_W-1:0] ACT_SUB   = 3'd2;
  localparam logic [ACT_W-1:0] ACT_MUL   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_DIV   = 3'd4;
  localparam logic [ACT_W-1:0] ACT_PEEK  = 3'd5;
  localparam logic [ACT_W-1:0] ACT_CLEAR = 3'd6;

  // Per-cell shift control: en moves data, from_up pulls from deeper in the stack
  // (pop by one, or by two with skip), else the cell takes its neighbor on the top side.
  typedef struct packed {
    logic en;
    logic from_up;
    logic skip;
  } cell_ctl_t;

endpackage
`default_nettype wire

### rtl/rpnsc_cell.sv
// One stack cell: holds an entry and shifts toward or away from the top.
`default_nettype none
module rpnsc_cell (
  input  wire                          clk_i,
  input  rpnsc_pkg::cell_ctl_t         ctl_i,
  input  wire [rpnsc_pkg::DATA_W-1:0]  down_i,
  input  wire [rpnsc_pkg::DATA_W-1:0]  up_i,
  input  wire [rpnsc_pkg::DATA_W-1:0]  up2_i,
  output logic [rpnsc_pkg::DATA_W-1:0] data_o
);
  import rpnsc_pkg::*;

  logic [DATA_W-1:0] data_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      data_q <= ctl_i.from_up ? (ctl_i.skip ? up2_i : up_i) : down_i;
    end
  end

  assign data_o = data_q;

endmodule
`default_nettype wire

### rtl/rpnsc_div.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
`default_nettype none
module rpnsc_div (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          start_i,
  input  wire [rpnsc_pkg::DATA_W-1:0]  num_i,
  input  wire [rpnsc_pkg::DATA_W-1:0]  den_i,
  output logic                         done_o,
  output logic [rpnsc_pkg::DATA_W-1:0] quotient_o
);
  import rpnsc_pkg::*;

  localparam int unsigned STEPS = DATA_W;
  localparam int unsigned CW    = $clog2(STEPS + 1);

  logic          busy_q;
  logic          done_q;
  logic [CW-1:0] cnt_q;
  logic          neg_q;
  logic [DATA_W-1:0] rem_q;
  logic [DATA_W-1:0] quo_q;
  logic [DATA_W-1:0] den_q;
  logic [DATA_W:0]   trial;

  assign trial = {rem_q, quo_q[DATA_W-1]} - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(STEPS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= num_i[DATA_W-1] ^ den_i[DATA_W-1];
      quo_q <= num_i[DATA_W-1] ? (DATA_W'(0) - num_i) : num_i;
      den_q <= den_i[DATA_W-1] ? (DATA_W'(0) - den_i) : den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      if (!trial[DATA_W]) begin
        rem_q <= trial[DATA_W-1:0];
        quo_q <= {quo_q[DATA_W-2:0], 1'b1};
      end else begin
        rem_q <= {rem_q[DATA_W-2:0], quo_q[DATA_W-1]};
        quo_q <= {quo_q[DATA_W-2:0], 1'b0};
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? (DATA_W'(0) - quo_q) : quo_q;

endmodule
`default_nettype wire

### rtl/rpn_stack_calculator_core.sv
// Top level of the RPN stack calculator: sequencer, shifting cell stack, output register.
// Each request is registered on acceptance, then passes through the EXEC and DONE states;
// in DONE the result is written to the output register once the output slot is free, and
// a divide waits in the DIV state between them for the one-bit-per-cycle divider. One
// request is in work at a time; the next is taken once the result is registered.
// Reset (async, active low) empties the stack and clears out_valid; entry storage and output data are not cleared.
`default_nettype none
module rpn_stack_calculator_core #(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                in_valid_i,
  output logic                               in_stall_o,
  input  wire [rpnsc_pkg::ACT_W-1:0]         action_i,
  input  wire [rpnsc_pkg::VAL_W-1:0]         operand_value_i,
  output logic                               out_valid_o,
  input  wire                                out_stall_i,
  output logic signed [rpnsc_pkg::DATA_W-1:0] top_value_o,
  output logic                               is_empty_o,
  output logic                               divide_by_zero_o,
  output logic                               push_dropped_o,
  output logic [rpnsc_pkg::CNT_OUT_W-1:0]    entry_count_o
);
  import rpnsc_pkg::*;

  localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [ACT_W-1:0]  act_q;
  logic [VAL_W-1:0]  val_q;
  logic [DATA_W-1:0] prod_q;
  logic              out_valid_q;
  logic [DATA_W-1:0] top_q;
  logic              empty_q, dz_q, drop_q;
  logic [CNT_OUT_W-1:0] ocnt_q;

  logic [DATA_W-1:0] ent [STACK_DEPTH+2];
  logic [DATA_W-1:0] right, left, result, new_top, top_in;
  logic [DATA_W-1:0] div_quo;
  logic              div_done, div_start;
  logic              ge1, ge2, full, dz, drop, commit, slot_free, accept;
  cell_ctl_t         ctl_top, ctl_rest;
  logic [CNT_W+CNT_OUT_W-1:0] cnt_ext;

  assign accept    = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  assign slot_free = !out_valid_q || !out_stall_i;
  assign commit    = (state_q == ST_DONE) && slot_free;

  assign ge1  = (count_q != '0);
  assign ge2  = (count_q >= CNT_W'(2));
  assign full = (count_q == CNT_W'(STACK_DEPTH));

  assign right = ge1 ? ent[0] : '0;
  assign left  = ge2 ? ent[1] : '0;
  assign dz    = (act_q == ACT_DIV) && (right == '0);
  assign drop  = (act_q == ACT_PUSH) && full;
  assign div_start = (state_q == ST_EXEC) && (act_q == ACT_DIV) && (right != '0);

  // Cell chain
  assign ent[STACK_DEPTH]   = '0;
  assign ent[STACK_DEPTH+1] = '0;

  for (genvar gi = 0; gi < STACK_DEPTH; gi++) begin : g_cell
    if (gi == 0) begin : g_top
      rpnsc_cell u_cell (
        .clk_i  (clk_i),
        .ctl_i  (ctl_top),
        .down_i (top_in),
        .up_i   (ent[1]),
        .up2_i  (ent[2]),
        .data_o (ent[0])
      );
    end else begin : g_rest
      rpnsc_cell u_cell (
        .clk_i  (clk_i),
        .ctl_i  (ctl_rest),
        .down_i (ent[gi-1]),
        .up_i   (ent[gi+1]),
        .up2_i  (ent[gi+2]),
        .data_o (ent[gi])
      );
    end
  end

  rpnsc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .num_i      (left),
    .den_i      (right),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  always_comb begin
    case (act_q)
      ACT_ADD: result = left + right;
      ACT_SUB: result = left - right;
      ACT_MUL: result = prod_q;
      ACT_DIV: result = div_quo;
      default: result = '0;
    endcase
  end

  always_comb begin
    ctl_top  = '0;
    ctl_rest = '0;
    top_in   = result;
    count_d  = count_q;
    new_top  = ent[0];
    case (act_q) inside
      ACT_PUSH: begin
        top_in = {1'b0, val_q};
        if (!full) begin
          ctl_top  = '{en: 1'b1, from_up: 1'b0, skip: 1'b0};
          ctl_rest = '{en: 1'b1, from_up: 1'b0, skip: 1'b0};
          count_d  = count_q + CNT_W'(1);
          new_top  = {1'b0, val_q};
        end
      end
      ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV: begin
        if (dz) begin
          ctl_top  = '{en: 1'b1, from_up: 1'b1, skip: 1'b1};
          ctl_rest = '{en: 1'b1, from_up: 1'b1, skip: 1'b1};
          count_d  = ge2 ? (count_q - CNT_W'(2)) : '0;
          new_top  = ent[2];
        end else begin
          ctl_top  = '{en: 1'b1, from_up: 1'b0, skip: 1'b0};
          ctl_rest = '{en: 1'b1, from_up: 1'b1, skip: 1'b0};
          count_d  = ge2 ? (count_q - CNT_W'(1)) : CNT_W'(1);
          new_top  = result;
        end
      end
      ACT_CLEAR: begin
        count_d = '0;
      end
      default: begin
        count_d = count_q;
      end
    endcase
    if (!commit) begin
      ctl_top  = '0;
      ctl_rest = '0;
      count_d  = count_q;
    end
  end

  assign cnt_ext = {{CNT_OUT_W{1'b0}}, count_d};

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (accept) state_d = ST_EXEC;
      ST_EXEC: state_d = div_start ? ST_DIV : ST_DONE;
      ST_DIV:  if (div_done) state_d = ST_DONE;
      ST_DONE: if (slot_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q <= action_i;
      val_q <= operand_value_i;
    end
    if (state_q == ST_EXEC) begin
      prod_q <= left * right;
    end
    if (commit) begin
      top_q   <= (count_d == '0) ? '0 : new_top;
      empty_q <= (count_d == '0);
      dz_q    <= dz;
      drop_q  <= drop;
      ocnt_q  <= cnt_ext[CNT_OUT_W-1:0];
    end
  end

  assign out_valid_o      = out_valid_q;
  assign top_value_o      = top_q;
  assign is_empty_o       = empty_q;
  assign divide_by_zero_o = dz_q;
  assign push_dropped_o   = drop_q;
  assign entry_count_o    = ocnt_q;

endmodule
`default_nettype wire
